// ----- rtl/depq_pkg.sv -----
// Shared types and constants for the double-ended priority queue.
// Used by depq_cell and double_ended_priority_queue_core; no dependencies.
`default_nettype none

package depq_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_DEL_MAX = 2'd1;
  localparam logic [1:0] MODE_DEL_MIN = 2'd2;

  // Operation codes broadcast to every cell
  localparam logic [1:0] OP_HOLD    = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_DEL_MIN = 2'd2;
  localparam logic [1:0] OP_DEL_MAX = 2'd3;

  // Sentinels fed to the head cell from its missing left neighbor
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Contents of one cell as seen by its neighbors
  typedef struct packed {
    logic               vld;
    logic signed [31:0] asc;  // ascending row: cell 0 holds the minimum
    logic signed [31:0] dsc;  // descending row: cell 0 holds the maximum
  } depq_link_t;

  // Broadcast control for the row
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] val;
  } depq_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/double_ended_priority_queue_core.sv -----
// Top level of the double-ended priority queue: handshake, count and row of cells.
// Depends on depq_pkg and depq_cell.
`default_nettype none

// Double-ended priority queue of up to CAPACITY signed 32-bit values. Each
// input beat inserts a value, removes the largest or removes the smallest;
// each gives exactly one result beat in the next cycle. The store is a row of
// CAPACITY cells holding the same values twice, sorted ascending and sorted
// descending, so both extremes always sit in cell 0. Every cell updates from
// its neighbors in parallel, so one beat is taken every cycle while
// out_ready stays high (the output register frees in the same cycle it is
// taken); a result held by a low out_ready blocks the input until it goes.
// Full inserts, empty removals and mode 3 are refused with ok low and leave
// the store unchanged.
module double_ended_priority_queue_core
  import depq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_ok,
  output logic signed [31:0]      out_removed,
  output logic [7:0]              out_count_after,
  output logic                    out_now_empty,
  output logic                    out_now_full
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic               accept;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW+7:0]      count_wide;
  logic               ok_nxt;
  logic signed [31:0] removed_nxt;
  depq_ctl_t          ctl;
  depq_link_t         lnk [CAPACITY];
  depq_link_t         head_in;
  depq_link_t         tail_in;

  logic               out_valid_r;
  logic               ok_r;
  logic signed [31:0] removed_r;
  logic [7:0]         count_out_r;
  logic               empty_r;
  logic               full_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Decode the beat against the current count
  always_comb begin
    ctl.op      = OP_HOLD;
    ctl.val     = in_value;
    ok_nxt      = 1'b0;
    removed_nxt = '0;
    count_nxt   = count_r;
    case (in_mode)
      MODE_INSERT: begin
        if (count_r != CAP_CNT) begin
          ctl.op    = OP_INSERT;
          ok_nxt    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_DEL_MAX: begin
        if (count_r != '0) begin
          ctl.op      = OP_DEL_MAX;
          ok_nxt      = 1'b1;
          removed_nxt = lnk[0].dsc;
          count_nxt   = count_r - CW'(1);
        end
      end
      MODE_DEL_MIN: begin
        if (count_r != '0) begin
          ctl.op      = OP_DEL_MIN;
          ok_nxt      = 1'b1;
          removed_nxt = lnk[0].asc;
          count_nxt   = count_r - CW'(1);
        end
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
    if (!accept) begin
      ctl.op = OP_HOLD;
    end
  end

  assign count_wide = (CW + 8)'(count_nxt);

  // Row ends: the head sees sentinels that never win a compare
  assign head_in.vld = 1'b1;
  assign head_in.asc = VAL_MIN;
  assign head_in.dsc = VAL_MAX;
  assign tail_in.vld = 1'b0;
  assign tail_in.asc = '0;
  assign tail_in.dsc = '0;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    depq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .lft   ((i == 0) ? head_in : lnk[(i == 0) ? 0 : i - 1]),
      .rgt   ((i == CAPACITY - 1) ? tail_in : lnk[(i == CAPACITY - 1) ? i : i + 1]),
      .cur   (lnk[i])
    );
  end

  // Count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r        <= ok_nxt;
      removed_r   <= removed_nxt;
      count_out_r <= count_wide[7:0];
      empty_r     <= (count_nxt == '0);
      full_r      <= (count_nxt == CAP_CNT);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_removed     = removed_r;
  assign out_count_after = count_out_r;
  assign out_now_empty   = empty_r;
  assign out_now_full    = full_r;

endmodule

`default_nettype wire

// ----- rtl/depq_cell.sv -----
// One cell of the queue: a slot of the ascending row, a slot of the
// descending row and a shared valid bit. Depends on depq_pkg.
`default_nettype none

module depq_cell
  import depq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire depq_ctl_t  ctl,
  input  wire depq_link_t lft,
  input  wire depq_link_t rgt,
  output depq_link_t      cur
);

  logic               vld_r, vld_nxt;
  logic signed [31:0] asc_r, asc_nxt;
  logic signed [31:0] dsc_r, dsc_nxt;

  // insert compares: shift from the left, take the new value, or keep
  logic lft_gt, lft_lt, own_gt, own_lt;

  assign lft_gt = lft.vld && ($signed(lft.asc) > $signed(ctl.val));
  assign lft_lt = lft.vld && ($signed(lft.dsc) < $signed(ctl.val));
  assign own_gt = !vld_r || (asc_r > $signed(ctl.val));
  assign own_lt = !vld_r || (dsc_r < $signed(ctl.val));

  always_comb begin
    vld_nxt = vld_r;
    asc_nxt = asc_r;
    dsc_nxt = dsc_r;
    case (ctl.op)
      OP_INSERT: begin
        vld_nxt = vld_r | lft.vld;
        if (lft_gt) begin
          asc_nxt = lft.asc;
        end else if (own_gt) begin
          asc_nxt = ctl.val;
        end
        if (lft_lt) begin
          dsc_nxt = lft.dsc;
        end else if (own_lt) begin
          dsc_nxt = ctl.val;
        end
      end
      // min leaves the ascending head; the descending tail just drops
      OP_DEL_MIN: begin
        vld_nxt = rgt.vld;
        asc_nxt = rgt.asc;
      end
      // max leaves the descending head; the ascending tail just drops
      OP_DEL_MAX: begin
        vld_nxt = rgt.vld;
        dsc_nxt = rgt.dsc;
      end
      default: begin
        vld_nxt = vld_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asc_r <= asc_nxt;
    dsc_r <= dsc_nxt;
  end

  assign cur.vld = vld_r;
  assign cur.asc = asc_r;
  assign cur.dsc = dsc_r;

endmodule

`default_nettype wire
